@@ design/jrlm_pkg.sv @@
// ----------------------------------------------------------------------------
// jrlm_pkg
// Shared types, constants and helpers of the joint rate limit monitor.
// ----------------------------------------------------------------------------
package jrlm_pkg;

   localparam logic [30:0] SAT31      = 31'h7FFF_FFFF;
   localparam logic [29:0] FD_SCALE   = 30'd1000000000;
   localparam logic [9:0]  UTIL_SCALE = 10'd1000;
   localparam logic [16:0] TOL_ONE    = 17'h1_0000;
   localparam logic [15:0] UTIL_SAT   = 16'hFFFF;

   localparam logic [2:0] CSR_VEL_PRESENT = 3'd0;
   localparam logic [2:0] CSR_ACC_PRESENT = 3'd1;
   localparam logic [2:0] CSR_ALLOW_FD    = 3'd2;
   localparam logic [2:0] CSR_TOLERANCE   = 3'd3;

   typedef struct packed {
      logic              new_trajectory;
      logic              first_of_joint;
      logic              last_of_joint;
      logic [5:0]        joint_index;
      logic [31:0]       position;
      logic [31:0]       velocity_sample;
      logic [31:0]       acceleration_sample;
      logic [31:0]       step_ns;
      logic [30:0]       vel_limit;
      logic [30:0]       acc_limit;
   } sample_type;

   typedef struct packed {
      logic        vel_present;
      logic        acc_present;
      logic        allow_fd;
      logic [15:0] tolerance;
   } cfg_type;

   typedef struct packed {
      logic [5:0]  result_joint;
      logic        status;
      logic [30:0] peak_velocity;
      logic [30:0] peak_acceleration;
      logic        vel_over;
      logic        acc_over;
      logic [15:0] utilization_tenths;
      logic [30:0] overall_max_velocity;
      logic [5:0]  overall_velocity_joint;
      logic [30:0] overall_max_acceleration;
      logic [5:0]  overall_acceleration_joint;
      logic [15:0] overall_peak_utilization;
   } result_type;

   function automatic logic [30:0] abs_sat(input logic [31:0] v);
      logic [31:0] m;
      begin
         m = v[31] ? (~v + 32'd1) : v;
         return m[31] ? SAT31 : m[30:0];
      end
   endfunction

endpackage

@@ design/jrlm_divider.sv @@
// ----------------------------------------------------------------------------
// jrlm_divider
// Restoring divider, one quotient bit a cycle, quotient saturated to 31 bits.
// ----------------------------------------------------------------------------
module jrlm_divider
   import jrlm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [62:0] num,
   input  logic [31:0] den,
   output logic        busy,
   output logic        done,
   output logic [30:0] quotient
);

   logic [62:0] rem_ff, rem_in;
   logic [62:0] dsh_ff, dsh_in;
   logic [30:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [62:0] dstart;
   logic        ge;

   assign dstart = {den, 31'b0};
   assign ge     = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         if (num >= dstart) begin
            q_in    = SAT31;
            done_in = 1'b1;
         end else begin
            rem_in  = num;
            dsh_in  = dstart >> 1;
            q_in    = '0;
            cnt_in  = 5'd30;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? (rem_ff - dsh_ff) : rem_ff;
         q_in   = {q_ff[29:0], ge};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

@@ design/jrlm_queue.sv @@
// ----------------------------------------------------------------------------
// jrlm_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module jrlm_queue
   import jrlm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  sample_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       pop_valid,
   output sample_type pop_data
);

   sample_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

@@ design/jrlm_front.sv @@
// ----------------------------------------------------------------------------
// jrlm_front
// Request intake: holds one request, drops out-of-range joints, feeds queue.
// ----------------------------------------------------------------------------
module jrlm_front
   import jrlm_pkg::*;
#(
   parameter int unsigned MAX_JOINTS = 64
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  sample_type req_data,
   output logic       req_ready,
   output logic       push,
   output sample_type push_data,
   input  logic       full
);

   logic       hold_valid_ff;
   sample_type hold_ff;
   logic       in_range;
   logic       release_hold;

   assign in_range     = (9'(hold_ff.joint_index) < 9'(MAX_JOINTS));
   assign push         = hold_valid_ff && in_range && !full;
   assign release_hold = hold_valid_ff && (!in_range || !full);
   assign req_ready    = !hold_valid_ff || release_hold;
   assign push_data    = hold_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hold_ff <= req_data;
      end
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_ready) begin
         hold_valid_ff <= req_valid;
      end
   end

endmodule

@@ design/jrlm_back.sv @@
// ----------------------------------------------------------------------------
// jrlm_back
// Per-joint peak tracking, finite difference, limit checks and result register.
// ----------------------------------------------------------------------------
module jrlm_back
   import jrlm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pop_valid,
   input  sample_type pop_data,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_FD_MUL, S_FD_DIV, S_FD_WAIT, S_RES_V, S_RES_A,
      S_RES_U, S_RES_DIV, S_RES_WAIT, S_RES_FIN
   } state_type;

   state_type   state_ff;
   sample_type  cur_ff;
   logic [31:0] prev_pos_ff;
   logic        have_prev_ff;
   logic [30:0] pk_v_ff, pk_a_ff, lim_v_ff, lim_a_ff;
   logic [30:0] top_v_ff, top_a_ff;
   logic [5:0]  top_vj_ff, top_aj_ff;
   logic [15:0] top_u_ff, util_ff;
   logic [32:0] mag_ff;
   logic [62:0] mul_ff;
   logic [47:0] prod_ff;
   logic        vviol_ff, aviol_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;

   logic        div_start, div_busy, div_done;
   logic [30:0] div_q;
   logic [31:0] div_den;

   logic        eff_have_prev, need_fd;
   logic [30:0] base_pv, base_pa, v_abs, a_abs;
   logic signed [32:0] diff;
   logic [32:0] mag;
   logic [62:0] fd_num;
   logic [40:0] util_num;
   logic [16:0] tol_k;
   logic [47:0] prod_v, prod_a;
   logic        err, vv, av, out_free, fin_fire;
   logic [30:0] pv_o, pa_o, ntop_v, ntop_a;
   logic [5:0]  ntop_vj, ntop_aj;
   logic [15:0] util_o, ntop_u;

   assign pop = (state_ff == S_IDLE) && pop_valid;

   assign eff_have_prev = pop_data.first_of_joint ? 1'b0 : have_prev_ff;
   assign base_pv       = pop_data.first_of_joint ? '0 : pk_v_ff;
   assign base_pa       = pop_data.first_of_joint ? '0 : pk_a_ff;
   assign v_abs         = abs_sat(pop_data.velocity_sample);
   assign a_abs         = abs_sat(pop_data.acceleration_sample);
   assign need_fd       = !cfg.vel_present && eff_have_prev && (pop_data.step_ns > 32'd1);
   assign diff          = $signed({pop_data.position[31], pop_data.position})
                        - $signed({prev_pos_ff[31], prev_pos_ff});
   assign mag           = diff[32] ? 33'(-diff) : 33'(diff);

   assign fd_num   = 63'(mag_ff) * 63'(FD_SCALE);
   assign util_num = 41'(pk_v_ff) * 41'(UTIL_SCALE);
   assign tol_k    = TOL_ONE + 17'(cfg.tolerance);
   assign prod_v   = 48'(lim_v_ff) * 48'(tol_k);
   assign prod_a   = 48'(lim_a_ff) * 48'(tol_k);

   assign div_start = (state_ff == S_FD_DIV) || (state_ff == S_RES_DIV);
   assign div_den   = (state_ff == S_FD_DIV) ? cur_ff.step_ns : {1'b0, lim_v_ff};

   jrlm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (mul_ff),
      .den      (div_den),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // result of the joint and the running maxima
   always_comb begin
      err     = !cfg.vel_present && !cfg.allow_fd;
      pv_o    = err ? '0 : pk_v_ff;
      pa_o    = err ? '0 : pk_a_ff;
      util_o  = err ? '0 : util_ff;
      vv      = !err && (lim_v_ff != '0) && vviol_ff;
      av      = !err && aviol_ff;
      ntop_v  = top_v_ff;
      ntop_vj = top_vj_ff;
      ntop_a  = top_a_ff;
      ntop_aj = top_aj_ff;
      ntop_u  = top_u_ff;
      if (pv_o > top_v_ff) begin
         ntop_v  = pv_o;
         ntop_vj = cur_ff.joint_index;
      end
      if (pa_o > top_a_ff) begin
         ntop_a  = pa_o;
         ntop_aj = cur_ff.joint_index;
      end
      if (util_o > top_u_ff) begin
         ntop_u = util_o;
      end
      out_free = !rsp_valid_ff || rsp_ready;
      fin_fire = (state_ff == S_RES_FIN) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_pos_ff  <= '0;
         have_prev_ff <= 1'b0;
         pk_v_ff      <= '0;
         pk_a_ff      <= '0;
         lim_v_ff     <= '0;
         lim_a_ff     <= '0;
         top_v_ff     <= '0;
         top_vj_ff    <= '0;
         top_a_ff     <= '0;
         top_aj_ff    <= '0;
         top_u_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fin_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop_valid) begin
                  cur_ff <= pop_data;
                  mag_ff <= mag;
                  if (pop_data.new_trajectory) begin
                     top_v_ff  <= '0;
                     top_vj_ff <= '0;
                     top_a_ff  <= '0;
                     top_aj_ff <= '0;
                     top_u_ff  <= '0;
                  end
                  if (pop_data.first_of_joint) begin
                     lim_v_ff <= pop_data.vel_limit;
                     lim_a_ff <= pop_data.acc_limit;
                  end
                  pk_v_ff <= (cfg.vel_present && v_abs > base_pv) ? v_abs : base_pv;
                  pk_a_ff <= (cfg.acc_present && a_abs > base_pa) ? a_abs : base_pa;
                  prev_pos_ff  <= pop_data.position;
                  have_prev_ff <= !pop_data.last_of_joint;
                  if (need_fd) begin
                     state_ff <= S_FD_MUL;
                  end else if (pop_data.last_of_joint) begin
                     state_ff <= S_RES_V;
                  end
               end
            end
            S_FD_MUL: begin
               mul_ff   <= fd_num;
               state_ff <= S_FD_DIV;
            end
            S_FD_DIV: begin
               state_ff <= S_FD_WAIT;
            end
            S_FD_WAIT: begin
               if (div_done) begin
                  if (div_q > pk_v_ff) pk_v_ff <= div_q;
                  state_ff <= cur_ff.last_of_joint ? S_RES_V : S_IDLE;
               end
            end
            S_RES_V: begin
               prod_ff  <= prod_v;
               state_ff <= S_RES_A;
            end
            S_RES_A: begin
               vviol_ff <= ({1'b0, pk_v_ff, 16'b0} > prod_ff);
               prod_ff  <= prod_a;
               state_ff <= S_RES_U;
            end
            S_RES_U: begin
               aviol_ff <= cfg.acc_present && (lim_a_ff != '0)
                        && ({1'b0, pk_a_ff, 16'b0} > prod_ff);
               mul_ff   <= 63'(util_num);
               if (lim_v_ff != '0) begin
                  state_ff <= S_RES_DIV;
               end else begin
                  util_ff  <= '0;
                  state_ff <= S_RES_FIN;
               end
            end
            S_RES_DIV: begin
               state_ff <= S_RES_WAIT;
            end
            S_RES_WAIT: begin
               if (div_done) begin
                  util_ff  <= (div_q > 31'(UTIL_SAT)) ? UTIL_SAT : div_q[15:0];
                  state_ff <= S_RES_FIN;
               end
            end
            S_RES_FIN: begin
               if (out_free) begin
                  top_v_ff  <= ntop_v;
                  top_vj_ff <= ntop_vj;
                  top_a_ff  <= ntop_a;
                  top_aj_ff <= ntop_aj;
                  top_u_ff  <= ntop_u;
                  rsp_ff.result_joint               <= cur_ff.joint_index;
                  rsp_ff.status                     <= err;
                  rsp_ff.peak_velocity              <= pv_o;
                  rsp_ff.peak_acceleration          <= pa_o;
                  rsp_ff.vel_over                   <= vv;
                  rsp_ff.acc_over                   <= av;
                  rsp_ff.utilization_tenths         <= util_o;
                  rsp_ff.overall_max_velocity       <= ntop_v;
                  rsp_ff.overall_velocity_joint     <= ntop_vj;
                  rsp_ff.overall_max_acceleration   <= ntop_a;
                  rsp_ff.overall_acceleration_joint <= ntop_aj;
                  rsp_ff.overall_peak_utilization   <= ntop_u;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status) |->
         (rsp_ff.peak_velocity == '0 && rsp_ff.utilization_tenths == '0))
      else $error("error result carries nonzero peak");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RES_FIN))
      else $error("result raised outside finish step");

endmodule

@@ design/joint_rate_limit_monitor_top.sv @@
// ----------------------------------------------------------------------------
// joint_rate_limit_monitor_top
// Joint velocity and acceleration limit monitor over streamed waypoints.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  one waypoint sample
//   rsp_     out        rsp_valid/rsp_ready  one joint result on its last sample
//   csr_     in         csr_wr_en            csr_index, csr_wdata
//
// requests reach the back through the front hold register and a queue entry; it takes
// plain samples one a cycle, finite difference holds it for a multiply and a division
// (a saturated quotient skips the bit steps); a last sample adds the limit checks,
// utilisation division and finish, held while rsp_valid is high and rsp_ready low
// reset is synchronous and clears all control and tracking state
// the two-entry queue lets intake run on while the back stalls on rsp_ready
// ----------------------------------------------------------------------------
module joint_rate_limit_monitor_top
   import jrlm_pkg::*;
#(
   parameter int unsigned MAX_JOINTS = 64
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_new_trajectory,
   input  logic        req_first_of_joint,
   input  logic        req_last_of_joint,
   input  logic [5:0]  req_joint_index,
   input  logic signed [31:0] req_position,
   input  logic signed [31:0] req_velocity_sample,
   input  logic signed [31:0] req_acceleration_sample,
   input  logic [31:0] req_step_ns,
   input  logic [30:0] req_vel_limit,
   input  logic [30:0] req_acc_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_result_joint,
   output logic        rsp_status,
   output logic [30:0] rsp_peak_velocity,
   output logic [30:0] rsp_peak_acceleration,
   output logic        rsp_vel_over,
   output logic        rsp_acc_over,
   output logic [15:0] rsp_utilization_tenths,
   output logic [30:0] rsp_overall_max_velocity,
   output logic [5:0]  rsp_overall_velocity_joint,
   output logic [30:0] rsp_overall_max_acceleration,
   output logic [5:0]  rsp_overall_acceleration_joint,
   output logic [15:0] rsp_overall_peak_utilization
);

   cfg_type    cfg_ff;
   sample_type req_data, push_data, pop_data;
   result_type rsp_data;
   logic       push, full, pop, pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vel_present <= 1'b1;
         cfg_ff.acc_present <= 1'b1;
         cfg_ff.allow_fd    <= 1'b1;
         cfg_ff.tolerance   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_VEL_PRESENT: cfg_ff.vel_present <= csr_wdata[0];
            CSR_ACC_PRESENT: cfg_ff.acc_present <= csr_wdata[0];
            CSR_ALLOW_FD:    cfg_ff.allow_fd    <= csr_wdata[0];
            CSR_TOLERANCE:   cfg_ff.tolerance   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      req_data.new_trajectory      = req_new_trajectory;
      req_data.first_of_joint      = req_first_of_joint;
      req_data.last_of_joint       = req_last_of_joint;
      req_data.joint_index         = req_joint_index;
      req_data.position            = req_position;
      req_data.velocity_sample     = req_velocity_sample;
      req_data.acceleration_sample = req_acceleration_sample;
      req_data.step_ns             = req_step_ns;
      req_data.vel_limit           = req_vel_limit;
      req_data.acc_limit           = req_acc_limit;
   end

   jrlm_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   jrlm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   jrlm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_result_joint               = rsp_data.result_joint;
   assign rsp_status                     = rsp_data.status;
   assign rsp_peak_velocity              = rsp_data.peak_velocity;
   assign rsp_peak_acceleration          = rsp_data.peak_acceleration;
   assign rsp_vel_over                   = rsp_data.vel_over;
   assign rsp_acc_over                   = rsp_data.acc_over;
   assign rsp_utilization_tenths         = rsp_data.utilization_tenths;
   assign rsp_overall_max_velocity       = rsp_data.overall_max_velocity;
   assign rsp_overall_velocity_joint     = rsp_data.overall_velocity_joint;
   assign rsp_overall_max_acceleration   = rsp_data.overall_max_acceleration;
   assign rsp_overall_acceleration_joint = rsp_data.overall_acceleration_joint;
   assign rsp_overall_peak_utilization   = rsp_data.overall_peak_utilization;

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the joint rate limit monitor: waypoint requests are
// driven in random bursts, an internal predictor tracks joint peaks, limit
// checks and trajectory maxima, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb
   import jrlm_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = CSR_VEL_PRESENT;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sample_type  req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   result_type  got;

   joint_rate_limit_monitor_top i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_new_trajectory(req_item.new_trajectory),
      .req_first_of_joint(req_item.first_of_joint),
      .req_last_of_joint(req_item.last_of_joint),
      .req_joint_index(req_item.joint_index),
      .req_position(req_item.position),
      .req_velocity_sample(req_item.velocity_sample),
      .req_acceleration_sample(req_item.acceleration_sample),
      .req_step_ns(req_item.step_ns),
      .req_vel_limit(req_item.vel_limit),
      .req_acc_limit(req_item.acc_limit),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_joint(got.result_joint),
      .rsp_status(got.status),
      .rsp_peak_velocity(got.peak_velocity),
      .rsp_peak_acceleration(got.peak_acceleration),
      .rsp_vel_over(got.vel_over),
      .rsp_acc_over(got.acc_over),
      .rsp_utilization_tenths(got.utilization_tenths),
      .rsp_overall_max_velocity(got.overall_max_velocity),
      .rsp_overall_velocity_joint(got.overall_velocity_joint),
      .rsp_overall_max_acceleration(got.overall_max_acceleration),
      .rsp_overall_acceleration_joint(got.overall_acceleration_joint),
      .rsp_overall_peak_utilization(got.overall_peak_utilization)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   cfg_type     cfg;
   logic [31:0] last_pos;
   logic        pos_valid;
   logic [30:0] peak_vel, peak_acc, lim_vel, lim_acc;
   logic [30:0] best_vel, best_acc;
   logic [5:0]  best_vel_joint, best_acc_joint;
   logic [15:0] best_util;

   sample_type  pending_q[$];
   result_type  result_q[$];
   int          errors = 0;
   int          accepted = 0;
   int          queued = 0;
   longint      cycles = 0;
   bit          stim_done = 1'b0;

   function automatic logic [30:0] mag31(logic [31:0] v);
      logic [32:0] m;
      m = v[31] ? (33'd0 - {1'b1, v}) : {1'b0, v};
      return (m > 33'h7FFF_FFFF) ? 31'h7FFF_FFFF : m[30:0];
   endfunction

   function automatic bit over_limit(logic [30:0] pk, logic [30:0] lim);
      return ({33'd0, pk} << 16) > (64'(lim) * (64'd65536 + 64'(cfg.tolerance)));
   endfunction

   task automatic predict_sample(sample_type s);
      logic [30:0] v, a;
      logic [63:0] d, q, u;
      result_type r;
      if (s.new_trajectory) begin
         best_vel = '0; best_vel_joint = '0; best_acc = '0;
         best_acc_joint = '0; best_util = '0;
      end
      if (s.first_of_joint) begin
         lim_vel = s.vel_limit; lim_acc = s.acc_limit;
         peak_vel = '0; peak_acc = '0; pos_valid = 1'b0;
      end
      if (cfg.vel_present) begin
         v = mag31(s.velocity_sample);
         if (v > peak_vel) peak_vel = v;
      end else if (pos_valid && s.step_ns > 1) begin
         d = 64'($signed(s.position)) - 64'($signed(last_pos));
         if (d[63]) d = -d;
         q = (d * 64'd1000000000) / 64'(s.step_ns);
         v = (q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : q[30:0];
         if (v > peak_vel) peak_vel = v;
      end
      last_pos = s.position;
      pos_valid = 1'b1;
      if (cfg.acc_present) begin
         a = mag31(s.acceleration_sample);
         if (a > peak_acc) peak_acc = a;
      end
      if (!s.last_of_joint) return;
      pos_valid = 1'b0;
      r = '0;
      r.result_joint = s.joint_index;
      r.status = !cfg.vel_present && !cfg.allow_fd;
      if (!r.status) begin
         r.peak_velocity = peak_vel;
         r.peak_acceleration = peak_acc;
         if (lim_vel != 0) begin
            u = (64'(peak_vel) * 64'd1000) / 64'(lim_vel);
            r.vel_over = over_limit(peak_vel, lim_vel);
            r.utilization_tenths = (u > 64'd65535) ? 16'hFFFF : u[15:0];
         end
         if (lim_acc != 0 && cfg.acc_present)
            r.acc_over = over_limit(peak_acc, lim_acc);
         if (peak_vel > best_vel) begin
            best_vel = peak_vel; best_vel_joint = s.joint_index;
         end
         if (peak_acc > best_acc) begin
            best_acc = peak_acc; best_acc_joint = s.joint_index;
         end
         if (r.utilization_tenths > best_util) best_util = r.utilization_tenths;
      end
      r.overall_max_velocity = best_vel;
      r.overall_velocity_joint = best_vel_joint;
      r.overall_max_acceleration = best_acc;
      r.overall_acceleration_joint = best_acc_joint;
      r.overall_peak_utilization = best_util;
      result_q.insert(result_q.size(), r);
   endtask

   // driver: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_sample(req_item);
            accepted <= accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_item <= pending_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 20);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor with its own stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      if (!reset) begin
         stall_phase <= stall_phase + 1;
         rsp_ready <= (stall_phase[9:7] == 3'd0) || (($urandom & 3) != 0);
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               $display("%0t unexpected result %p", $time, got);
               errors <= errors + 1;
            end else begin
               result_type e;
               e = result_q.pop_front();
               if (e !== got) begin
                  $display("%0t mismatch expected %p actual %p", $time, e, got);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_VEL_PRESENT: cfg.vel_present = val[0];
         CSR_ACC_PRESENT: cfg.acc_present = val[0];
         CSR_ALLOW_FD:    cfg.allow_fd = val[0];
         default:         cfg.tolerance = val;
      endcase
   endtask

   task automatic wait_idle();
      while (accepted != queued || result_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 200000) - 100000;
         default: return $urandom;
      endcase
   endfunction

   task automatic push(sample_type s);
      pending_q.insert(pending_q.size(), s);
      queued++;
   endtask

   task automatic push_joint(logic [5:0] j, int n, bit fresh);
      sample_type s;
      logic [31:0] p;
      p = rand_word();
      for (int k = 0; k < n; k++) begin
         s.new_trajectory = fresh && (k == 0);
         s.first_of_joint = (k == 0) || ($urandom_range(0, 40) == 0);
         s.last_of_joint = (k == n - 1);
         s.joint_index = j;
         p = ($urandom_range(0, 9) == 0) ? rand_word() : p + ($urandom_range(0, 4000) - 2000);
         s.position = p;
         s.velocity_sample = rand_word();
         s.acceleration_sample = rand_word();
         s.step_ns = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
                     ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1000, 10000000);
         s.vel_limit = ($urandom_range(0, 5) == 0) ? 31'd0 :
                       ($urandom_range(0, 5) == 0) ? 31'h7FFF_FFFF :
                       31'($urandom_range(1, 200000));
         s.acc_limit = ($urandom_range(0, 5) == 0) ? 31'd0 : 31'($urandom);
         push(s);
      end
   endtask

   initial begin
      sample_type s;
      cfg = '{vel_present: 1'b1, acc_present: 1'b1, allow_fd: 1'b1, tolerance: 16'd0};
      last_pos = '0; pos_valid = 1'b0;
      peak_vel = '0; peak_acc = '0; lim_vel = '0; lim_acc = '0;
      best_vel = '0; best_acc = '0; best_vel_joint = '0; best_acc_joint = '0;
      best_util = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, single waypoint joint, ties, missing first
      s = '0;
      s.new_trajectory = 1; s.first_of_joint = 1; s.last_of_joint = 1;
      s.joint_index = 6'd63; s.velocity_sample = 32'h8000_0000;
      s.acceleration_sample = 32'h8000_0000; s.step_ns = 32'hFFFF_FFFF;
      s.vel_limit = 31'd1; s.acc_limit = 31'h7FFF_FFFF;
      s.position = 32'h7FFF_FFFF;
      push(s);
      s.new_trajectory = 0; s.joint_index = 6'd0; s.velocity_sample = 32'h7FFF_FFFF;
      s.acceleration_sample = 32'h0000_0001; s.vel_limit = 31'h7FFF_FFFF;
      s.acc_limit = 31'd0; s.position = 32'h8000_0000;
      push(s);
      s.first_of_joint = 0; s.joint_index = 6'd5; s.velocity_sample = 32'hFFFF_FFFF;
      push(s);
      push_joint(6'd1, 4, 1'b0);
      wait_idle();

      write_reg(CSR_VEL_PRESENT, 16'd0);
      write_reg(CSR_TOLERANCE, 16'hFFFF);
      push_joint(6'd2, 3, 1'b1);
      s = '0; s.first_of_joint = 1; s.joint_index = 6'd3; s.position = 32'h8000_0000;
      s.step_ns = 32'd1000; s.vel_limit = 31'd100;
      push(s);
      s.first_of_joint = 0; s.position = 32'h7FFF_FFFF; s.step_ns = 32'd2;
      push(s);
      s.step_ns = 32'd0; push(s);
      s.last_of_joint = 1; s.step_ns = 32'd1; push(s);
      wait_idle();

      write_reg(CSR_ALLOW_FD, 16'd0);
      write_reg(CSR_ACC_PRESENT, 16'd0);
      push_joint(6'd4, 3, 1'b0);
      push_joint(6'd4, 1, 1'b0);
      wait_idle();

      // random phases over several settings
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_VEL_PRESENT, 16'($urandom_range(0, 1)));
         write_reg(CSR_ACC_PRESENT, 16'($urandom_range(0, 1)));
         write_reg(CSR_ALLOW_FD, 16'(($urandom_range(0, 3) != 0)));
         write_reg(CSR_TOLERANCE, (ph == 0) ? 16'd0 : (ph == 1) ? 16'hFFFF :
                   16'($urandom));
         for (int n = 0; n < 230; ) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            if ($urandom_range(0, 15) == 0) begin
               s = '0;
               s.joint_index = 6'($urandom);
               s.new_trajectory = $urandom; s.first_of_joint = $urandom;
               s.last_of_joint = $urandom; s.position = $urandom;
               s.velocity_sample = $urandom; s.acceleration_sample = $urandom;
               s.step_ns = $urandom; s.vel_limit = 31'($urandom);
               s.acc_limit = 31'($urandom);
               push(s);
               n++;
            end else begin
               push_joint(6'($urandom), len, $urandom_range(0, 7) == 0);
               n += len;
            end
         end
         wait_idle();
      end
      stim_done = 1'b1;
   end

   always @(posedge clock) begin
      if (stim_done) begin
         if (errors == 0) $display("tb: PASS");
         else $display("tb: FAIL");
         $finish;
      end else if (cycles > 2000000) begin
         $display("tb: FAIL");
         $finish;
      end
   end

endmodule
